FILE: hw/rtl/reciprocal_frequency_meter_defines.svh
// ----------------------------------------------------------------------------
// reciprocal frequency meter assertion macros
// shared property forms for the meter's checks
// ----------------------------------------------------------------------------
`ifndef RECIPROCAL_FREQUENCY_METER_DEFINES_SVH
`define RECIPROCAL_FREQUENCY_METER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RFM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rfm_pkg.sv
// ----------------------------------------------------------------------------
// rfm_pkg
// widths, register codes and controller/datapath types of the meter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfm_pkg;

    localparam int CAPTURE_W  = 16;
    localparam int COUNT_W    = 8;
    localparam int PERIOD_W   = 24;
    localparam int VALUE_W    = 40;
    localparam int CLOCK_W    = 32;
    localparam int WEIGHT_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // multiplier split: 40-bit operand in two 20-bit halves, 17-bit weight
    localparam int MUL_HALF_W = 20;
    localparam int MUL_B_W    = 17;
    localparam int MUL_P_W    = MUL_HALF_W + MUL_B_W;
    localparam int ACC_W      = 58;
    localparam int MUL_STEPS  = 4;
    localparam int AVG_SHIFT  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_RATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT     = 1'd1;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_CAPTURE = 1'b1;

    localparam logic [CLOCK_W-1:0]  CLOCK_RATE_RESET = 32'd16000000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET     = 16'd3277;
    localparam logic [MUL_B_W-1:0]  WEIGHT_ONE       = 17'd65536;
    localparam logic [ACC_W-1:0]    ROUND_HALF       = 58'd32768;

    typedef enum logic [1:0] {
        MS_OLD_LO = 2'd0,
        MS_OLD_HI = 2'd1,
        MS_NEW_LO = 2'd2,
        MS_NEW_HI = 2'd3
    } t_mul_sel;

    typedef struct packed {
        logic     tick;
        logic     capture;
        logic     div_step;
        logic     mul_step;
        t_mul_sel mul_sel;
        logic     acc_add;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic period_zero;
    } t_sts;

endpackage

FILE: hw/rtl/rfm_in_if.sv
// ----------------------------------------------------------------------------
// rfm_in_if
// event request channel: tick or capture with timer value
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rfm_in_if import rfm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [CAPTURE_W-1:0] capture_time;

    modport source (output valid, output opcode, output capture_time, input ready);
    modport sink   (input valid, input opcode, input capture_time, output ready);
endinterface

FILE: hw/rtl/rfm_out_if.sv
// ----------------------------------------------------------------------------
// rfm_out_if
// result request channel: period, instant and averaged frequency
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rfm_out_if import rfm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] period_ticks;
    logic [VALUE_W-1:0]  frequency_now;
    logic [VALUE_W-1:0]  avg_frequency;

    modport source (output valid, output period_ticks, output frequency_now,
                    output avg_frequency, input ready);
    modport sink   (input valid, input period_ticks, input frequency_now,
                    input avg_frequency, output ready);
endinterface

FILE: hw/rtl/rfm_ctrl.sv
// ----------------------------------------------------------------------------
// rfm_ctrl
// sequencer: accept, divide steps, multiply-accumulate steps, result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfm_ctrl import rfm_pkg::*; #(
    parameter int NUM_W = 40
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_opcode,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;
    logic             w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.mul_sel = t_mul_sel'(r_cnt[1:0]);
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_opcode == OP_CAPTURE) begin
                        o_cmd.capture = 1'b1;
                        n_cnt = '0;
                        if (!i_sts.period_zero) begin
                            n_state = S_DIV;
                        end
                    end else begin
                        o_cmd.tick = 1'b1;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_cnt   = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // product of step k is registered, then added to the accumulator in the next step
                o_cmd.mul_step = (r_cnt != MUL_LAST);
                o_cmd.acc_add  = (r_cnt != '0);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == MUL_LAST) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hw/rtl/rfm_datapath.sv
// ----------------------------------------------------------------------------
// rfm_datapath
// period arithmetic, restoring divider, shared multiplier and result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfm_datapath import rfm_pkg::*; #(
    parameter int COUNTER_WIDTH = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [CAPTURE_W-1:0]  i_capture_time,
    output logic [PERIOD_W-1:0]   o_period_ticks,
    output logic [VALUE_W-1:0]    o_frequency_now,
    output logic [VALUE_W-1:0]    o_avg_frequency
);

    localparam int NUM_W = CLOCK_W + FRACTION_BITS;
    localparam int AW    = (COUNTER_WIDTH + COUNT_W > PERIOD_W) ?
                           (COUNTER_WIDTH + COUNT_W) : PERIOD_W;
    localparam int QX    = ((NUM_W > VALUE_W) ? NUM_W : VALUE_W) + 1;
    localparam logic [CAPTURE_W-1:0] CAP_MASK = (COUNTER_WIDTH >= CAPTURE_W) ?
        {CAPTURE_W{1'b1}} : CAPTURE_W'((64'd1 << COUNTER_WIDTH) - 64'd1);

    logic [CLOCK_W-1:0]   r_clock_rate;
    logic [WEIGHT_W-1:0]  r_weight;
    logic [CAPTURE_W-1:0] r_last_cap;
    logic [COUNT_W-1:0]   r_ovf_cnt;
    logic [VALUE_W-1:0]   r_smooth;
    logic [PERIOD_W-1:0]  r_period;
    logic [PERIOD_W-1:0]  r_rem;
    logic [NUM_W-1:0]     r_quo;
    logic [ACC_W-1:0]     r_prod;
    logic [ACC_W-1:0]     r_acc;
    logic [PERIOD_W-1:0]  r_out_period;
    logic [VALUE_W-1:0]   r_out_freq;
    logic [VALUE_W-1:0]   r_out_smooth;

    logic [CAPTURE_W-1:0]  w_cap;
    logic [AW-1:0]         w_sum;
    logic [PERIOD_W-1:0]   w_period;
    logic [PERIOD_W:0]     w_rem_sh;
    logic [PERIOD_W:0]     w_rem_sub;
    logic                  w_ge;
    logic [QX-1:0]         w_quo_ext;
    logic [VALUE_W-1:0]    w_freq;
    logic [MUL_B_W-1:0]    w_wc;
    logic [MUL_HALF_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0]    w_mul_b;
    logic [MUL_P_W-1:0]    w_mul_p;
    logic [VALUE_W-1:0]    w_blend;

    // period = capture + count * 2^counter_width - last capture, mod 2^24
    assign w_cap    = i_capture_time & CAP_MASK;
    assign w_sum    = (AW'(r_ovf_cnt) << COUNTER_WIDTH) + AW'(w_cap) - AW'(r_last_cap);
    assign w_period = w_sum[PERIOD_W-1:0];
    assign o_sts.period_zero = (w_period == '0);

    // one restoring step: shift in the next numerator bit
    assign w_rem_sh  = {r_rem, r_quo[NUM_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_period};
    assign w_ge      = (w_rem_sh >= {1'b0, r_period});

    // saturate a quotient wider than 40 bits
    assign w_quo_ext = QX'(r_quo);
    assign w_freq    = (|w_quo_ext[QX-1:VALUE_W]) ? {VALUE_W{1'b1}} :
                       w_quo_ext[VALUE_W-1:0];

    assign w_wc = WEIGHT_ONE - MUL_B_W'(r_weight);

    always_comb begin
        case (i_cmd.mul_sel)
            MS_OLD_LO: begin
                w_mul_a = r_smooth[MUL_HALF_W-1:0];
                w_mul_b = w_wc;
            end
            MS_OLD_HI: begin
                w_mul_a = r_smooth[VALUE_W-1:MUL_HALF_W];
                w_mul_b = w_wc;
            end
            MS_NEW_LO: begin
                w_mul_a = w_freq[MUL_HALF_W-1:0];
                w_mul_b = MUL_B_W'(r_weight);
            end
            default: begin
                w_mul_a = w_freq[VALUE_W-1:MUL_HALF_W];
                w_mul_b = MUL_B_W'(r_weight);
            end
        endcase
    end

    assign w_mul_p = MUL_P_W'(w_mul_a) * MUL_P_W'(w_mul_b);
    assign w_blend = r_acc[AVG_SHIFT +: VALUE_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_rate <= CLOCK_RATE_RESET;
            r_weight     <= WEIGHT_RESET;
            r_last_cap   <= '0;
            r_ovf_cnt    <= '0;
            r_smooth     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_CLOCK_RATE: r_clock_rate <= i_cfg_data;
                    REG_WEIGHT:     r_weight     <= i_cfg_data[WEIGHT_W-1:0];
                endcase
            end
            if (i_cmd.tick) begin
                r_ovf_cnt <= r_ovf_cnt + 1'b1;
            end
            if (i_cmd.capture) begin
                r_last_cap <= w_cap;
                r_ovf_cnt  <= '0;
            end
            if (i_cmd.out_load) begin
                r_smooth <= w_blend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_period <= w_period;
            r_rem    <= '0;
            r_quo    <= NUM_W'(r_clock_rate) << FRACTION_BITS;
            r_acc    <= ROUND_HALF;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_rem_sub[PERIOD_W-1:0] : w_rem_sh[PERIOD_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
        if (i_cmd.mul_step) begin
            if (i_cmd.mul_sel == MS_OLD_HI || i_cmd.mul_sel == MS_NEW_HI) begin
                r_prod <= ACC_W'(w_mul_p) << MUL_HALF_W;
            end else begin
                r_prod <= ACC_W'(w_mul_p);
            end
        end
        if (i_cmd.acc_add) begin
            r_acc <= r_acc + r_prod;
        end
        if (i_cmd.out_load) begin
            r_out_period <= r_period;
            r_out_freq   <= w_freq;
            r_out_smooth <= w_blend;
        end
    end

    assign o_period_ticks  = r_out_period;
    assign o_frequency_now = r_out_freq;
    assign o_avg_frequency = r_out_smooth;

endmodule

FILE: hw/rtl/reciprocal_frequency_meter.sv
// ----------------------------------------------------------------------------
// reciprocal_frequency_meter
// period capture, reciprocal division and exponential averaging of frequency
// ----------------------------------------------------------------------------
//   channel    dir  payload                                         handshake
//   i_item     in   opcode, capture_time                            valid/ready
//   o_result   out  period_ticks, frequency_now, avg_frequency      valid/ready
//   i_cfg_*    in   index 0 clock_rate, index 1 smoothing_weight    write enable
//
// a tick, or a capture with zero period, leaves the block idle and ready
// a capture with a result runs the restoring divider, one quotient bit a
// cycle, then four steps of the shared 20x17 multiplier and a final
// accumulate step
// the result register parts the sides: a finished result waits there while
// the next request is taken; a later result waits until it is taken
// synchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "reciprocal_frequency_meter_defines.svh"

module reciprocal_frequency_meter import rfm_pkg::*; #(
    parameter int COUNTER_WIDTH = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rfm_in_if.sink                i_item,
    rfm_out_if.source             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // numerator is clock_rate shifted up by the fraction bits
    localparam int NUM_W = CLOCK_W + FRACTION_BITS;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer: owns ready, result valid and all step counting
    rfm_ctrl #(
        .NUM_W (NUM_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_opcode (i_item.opcode),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // datapath: registers, period math, divider, multiplier, result register
    rfm_datapath #(
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_capture_time  (i_item.capture_time),
        .o_period_ticks  (o_result.period_ticks),
        .o_frequency_now (o_result.frequency_now),
        .o_avg_frequency (o_result.avg_frequency)
    );

    // no request is taken while the divider or multiplier is busy
    `RFM_ASSERT_NOW(a_no_accept_busy, i_clk, i_rst_n, i_item.valid && i_item.ready, !w_cmd.div_step && !w_cmd.mul_step, "request accepted while busy")

    // a new result never overwrites one that is still waiting
    `RFM_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, w_cmd.out_load, !o_result.valid || o_result.ready, "result register overwritten")

    // a capture with zero period leaves the block ready for the next request
    `RFM_ASSERT_NEXT(a_zero_period_idle, i_clk, i_rst_n, i_item.valid && i_item.ready && i_item.opcode && w_sts.period_zero, i_item.ready, "zero period started work")

endmodule

FILE: bench/rfm_reading_checker.sv
// ----------------------------------------------------------------------------
// rfm_reading_checker
// watches the event and result channels and the register port, predicts each
// frequency reading and compares it field by field with what the meter emits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfm_reading_checker import rfm_pkg::*; #(
    parameter int COUNTER_WIDTH = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rfm_in_if                     i_item_mon,
    rfm_out_if                    i_result_mon,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_failures
);

    typedef struct packed {
        logic [PERIOD_W-1:0] period_ticks;
        logic [VALUE_W-1:0]  frequency_now;
        logic [VALUE_W-1:0]  avg_frequency;
    } t_reading;

    // predicted meter state and registers
    logic [CLOCK_W-1:0]   clock_hz;
    logic [WEIGHT_W-1:0]  new_weight;
    logic [CAPTURE_W-1:0] prev_capture;
    logic [COUNT_W-1:0]   overflow_ticks;
    logic [VALUE_W-1:0]   running_average;

    t_reading expected_readings[$];
    int       fail_count;

    // truncated Q32.F reciprocal, saturating at the output width
    function automatic logic [VALUE_W-1:0] reciprocal_hz(
        input logic [CLOCK_W-1:0]  rate,
        input logic [PERIOD_W-1:0] period
    );
        logic [63:0] quotient;
        quotient = ({32'd0, rate} << FRACTION_BITS) / {40'd0, period};
        if (quotient > {24'd0, {VALUE_W{1'b1}}})
            return {VALUE_W{1'b1}};
        return quotient[VALUE_W-1:0];
    endfunction

    // weighted average, rounded half up
    function automatic logic [VALUE_W-1:0] blend_average(
        input logic [VALUE_W-1:0]  old_avg,
        input logic [VALUE_W-1:0]  instant,
        input logic [WEIGHT_W-1:0] w
    );
        logic [63:0] acc;
        acc = 64'(old_avg) * (64'(WEIGHT_ONE) - 64'(w)) + 64'(instant) * 64'(w)
            + 64'(ROUND_HALF);
        return acc[AVG_SHIFT +: VALUE_W];
    endfunction

    always @(posedge i_clk) begin : monitor
        t_reading            got;
        t_reading            want;
        logic [63:0]         span;
        logic [63:0]         masked;
        logic [PERIOD_W-1:0] period;
        logic [VALUE_W-1:0]  instant;

        if (!i_rst_n) begin
            clock_hz        = CLOCK_RATE_RESET;
            new_weight      = WEIGHT_RESET;
            prev_capture    = '0;
            overflow_ticks  = '0;
            running_average = '0;
            fail_count      = 0;
            expected_readings.delete();
        end else begin
            if (i_result_mon.valid && i_result_mon.ready) begin
                got.period_ticks  = i_result_mon.period_ticks;
                got.frequency_now = i_result_mon.frequency_now;
                got.avg_frequency = i_result_mon.avg_frequency;
                if (expected_readings.size() == 0) begin
                    $error("unexpected reading: period_ticks %0d frequency_now %0d",
                           got.period_ticks, got.frequency_now);
                    fail_count++;
                end else begin
                    want = expected_readings.pop_front();
                    if (got.period_ticks !== want.period_ticks) begin
                        $error("period_ticks: expected %0d, got %0d",
                               want.period_ticks, got.period_ticks);
                        fail_count++;
                    end
                    if (got.frequency_now !== want.frequency_now) begin
                        $error("frequency_now: expected %0d, got %0d",
                               want.frequency_now, got.frequency_now);
                        fail_count++;
                    end
                    if (got.avg_frequency !== want.avg_frequency) begin
                        $error("avg_frequency: expected %0d, got %0d",
                               want.avg_frequency, got.avg_frequency);
                        fail_count++;
                    end
                end
            end

            if (i_item_mon.valid && i_item_mon.ready) begin
                if (i_item_mon.opcode == OP_TICK) begin
                    overflow_ticks = overflow_ticks + 1'b1;
                end else begin
                    masked = 64'(i_item_mon.capture_time)
                           & ((64'd1 << COUNTER_WIDTH) - 64'd1);
                    span   = masked + (64'(overflow_ticks) << COUNTER_WIDTH)
                           - 64'(prev_capture);
                    period = span[PERIOD_W-1:0];
                    prev_capture   = masked[CAPTURE_W-1:0];
                    overflow_ticks = '0;
                    if (period != '0) begin
                        instant         = reciprocal_hz(clock_hz, period);
                        running_average = blend_average(running_average, instant,
                                                        new_weight);
                        expected_readings.push_back('{period, instant, running_average});
                    end
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_CLOCK_RATE: clock_hz   = i_cfg_data[CLOCK_W-1:0];
                    REG_WEIGHT:     new_weight = i_cfg_data[WEIGHT_W-1:0];
                    default: ;
                endcase
            end
        end

        o_pending  <= expected_readings.size();
        o_failures <= fail_count;
    end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the reciprocal frequency meter: directed events,
// then random tick/capture sequences over several register settings and
// three idling patterns; checking lives in rfm_reading_checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import rfm_pkg::*;;

    localparam int COUNTER_WIDTH = 16;
    localparam int FRACTION_BITS = 8;
    localparam int SEGMENTS      = 6;
    localparam int RANDOM_EVENTS = 26;      // per setting, long tick runs come on top
    localparam int DRAIN_CYCLES  = 64;      // long enough for a busy capture to finish
    localparam int WATCHDOG_NS   = 5_000_000;

    logic i_clk;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rfm_in_if  item_ch ();
    rfm_out_if result_ch ();

    int pending_results;
    int failures;

    // idling knobs, percent of cycles
    int sender_idle_pct;
    int receiver_idle_pct;
    int send_calm;
    int recv_calm;

    // what the stimulus side knows of the meter, used to shape sequences
    logic [CAPTURE_W-1:0] last_sent_capture;
    int                   events_sent;

    logic [CLOCK_W-1:0]  rate_plan[SEGMENTS];
    logic [WEIGHT_W-1:0] weight_plan[SEGMENTS];

    reciprocal_frequency_meter #(
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch),
        .o_result    (result_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    rfm_reading_checker #(
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_mon   (item_ch),
        .i_result_mon (result_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending_results),
        .o_failures   (failures)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case a request or reading never comes
    initial begin
        #(WATCHDOG_NS);
        $display("reciprocal_frequency_meter test failed");
        $finish;
    end

    // result side: random back-pressure with occasional stretches of steady ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            recv_calm       <= 0;
        end else if (recv_calm != 0) begin
            recv_calm       <= recv_calm - 1;
            result_ch.ready <= 1'b1;
        end else begin
            if ($urandom_range(0, 49) == 0)
                recv_calm <= $urandom_range(20, 80);
            result_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // one event request; valid stays high into the next request unless a gap is taken
    task automatic offer_event(input logic op, input logic [CAPTURE_W-1:0] value);
        while (send_calm == 0 && sender_idle_pct != 0
               && $urandom_range(0, 99) < sender_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        if (send_calm != 0)
            send_calm--;
        else if ($urandom_range(0, 39) == 0)
            send_calm = $urandom_range(10, 40);
        item_ch.valid        <= 1'b1;
        item_ch.opcode       <= op;
        item_ch.capture_time <= value;
        do @(posedge i_clk); while (!item_ch.ready);
        events_sent++;
        if (op == OP_CAPTURE) begin
            last_sent_capture = value;
        end
    endtask

    // timer value rides along on ticks too, the meter must ignore it
    task automatic send_tick();
        offer_event(OP_TICK, CAPTURE_W'($urandom()));
    endtask

    task automatic send_capture(input logic [CAPTURE_W-1:0] value);
        offer_event(OP_CAPTURE, value);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_tick();
    endtask

    // drop valid, wait out every pending reading, then let the divider go idle
    task automatic settle();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // both registers back to back, write enable held across the pair
    task automatic program_meter(input logic [CLOCK_W-1:0] rate,
                                 input logic [WEIGHT_W-1:0] weight);
        cfg_we    <= 1'b1;
        cfg_index <= REG_CLOCK_RATE;
        cfg_data  <= rate;
        @(posedge i_clk);
        cfg_index <= REG_WEIGHT;
        cfg_data  <= {{(CFG_DATA_W-WEIGHT_W){1'b0}}, weight};
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic directed_events();
        send_capture(16'h0000);             // zero period straight out of reset
        send_capture(16'h0001);             // period of one, highest frequency
        send_capture(16'h0000);             // negative span wraps to the longest period
        send_ticks(2);
        send_capture(16'h0000);             // two overflows, same timer value
        send_capture(16'hFFFF);
        send_capture(16'hFFFF);             // repeat value, no reading
        send_tick();
        send_capture(16'hFFFF);             // exactly one overflow
        send_capture(16'h5555);
        send_capture(16'hAAAA);
        send_ticks(3);
        send_capture(16'hAAAA);
        send_tick();
        send_capture(16'h0000);             // overflow with a smaller capture
    endtask

    task automatic random_events(input int quota);
        int                   pick;
        logic [CAPTURE_W-1:0] near;
        int                   stop;

        stop = events_sent + quota;
        while (events_sent < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                // typical measurement: a few overflows then a capture
                send_ticks($urandom_range(0, 3));
                send_capture(CAPTURE_W'($urandom()));
            end else if (pick < 75) begin
                // same timer value again, zero period when no overflow is pending
                send_capture(last_sent_capture);
            end else if (pick < 90) begin
                // short span forward or just behind, high or wrapped periods
                near = $urandom_range(0, 1) ? last_sent_capture + CAPTURE_W'($urandom_range(1, 16))
                                            : last_sent_capture - CAPTURE_W'($urandom_range(1, 16));
                send_capture(near);
            end else if (pick < 95) begin
                send_tick();
            end else begin
                send_capture(CAPTURE_W'($urandom()));
            end
        end
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= REG_CLOCK_RATE;
        cfg_data             <= '0;
        item_ch.valid        <= 1'b0;
        item_ch.opcode       <= OP_TICK;
        item_ch.capture_time <= '0;
        sender_idle_pct      = 36;
        receiver_idle_pct    = 53;
        send_calm            = 0;
        last_sent_capture    = '0;
        events_sent          = 0;

        // register plan: reset values, both extremes, a zero clock, then random
        rate_plan[0]   = CLOCK_RATE_RESET;
        weight_plan[0] = WEIGHT_RESET;
        rate_plan[1]   = '1;
        weight_plan[1] = '1;
        rate_plan[2]   = 32'd1;
        weight_plan[2] = '0;
        rate_plan[3]   = '0;
        weight_plan[3] = WEIGHT_W'($urandom());
        rate_plan[4]   = CLOCK_W'($urandom());
        weight_plan[4] = WEIGHT_W'($urandom());
        rate_plan[5]   = CLOCK_W'($urandom());
        weight_plan[5] = 16'd1;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            // two settings per idling pattern: receiver-heavy, sender-heavy, none
            case (seg / 2)
                0: begin
                    sender_idle_pct   = 36;
                    receiver_idle_pct = 53;
                end
                1: begin
                    sender_idle_pct   = 53;
                    receiver_idle_pct = 36;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            settle();
            program_meter(rate_plan[seg], weight_plan[seg]);
            if (seg == 0)
                directed_events();
            if (seg == 2) begin
                // full overflow count before the capture
                send_capture(CAPTURE_W'($urandom()));
                send_ticks(255);
                send_capture(CAPTURE_W'($urandom()));
            end
            if (seg == 4) begin
                // overflow count wraps past zero
                send_capture(CAPTURE_W'($urandom()));
                send_ticks($urandom_range(256, 259));
                send_capture(CAPTURE_W'($urandom()));
            end
            random_events(RANDOM_EVENTS);
        end

        settle();
        if (failures == 0)
            $display("reciprocal_frequency_meter test passed");
        else
            $display("reciprocal_frequency_meter test failed");
        $finish;
    end

endmodule
